>>> rtl/djs_pkg.sv
// Shared types and constants for the deadline job scheduler.
// No dependencies.
package djs_pkg;

    localparam int ID_W     = 8;
    localparam int DL_W     = 8;
    localparam int PROFIT_W = 16;
    localparam int SLOT_W   = 6;
    localparam int TOTAL_W  = 21;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_PLACE = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_EMPTY = 4'b1000
    } state_t;

    // Slot cell command, broadcast to the whole row of slot cells.
    typedef struct packed {
        logic       clear;
        logic       place;
        logic [6:0] deadline;
        logic       shift;
    } slot_cmd_t;

endpackage

>>> rtl/djs_job_cell.sv
// One job cell: holds a loaded job and its live flag (cleared when taken).
// Depends on djs_pkg.
module djs_job_cell
    import djs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                load,
    input  logic [ID_W-1:0]     load_id,
    input  logic [6:0]          load_deadline,
    input  logic [PROFIT_W-1:0] load_profit,
    input  logic                take,
    output logic                live,
    output logic [ID_W-1:0]     id,
    output logic [6:0]          deadline,
    output logic [PROFIT_W-1:0] profit
);

    logic                live_reg, live_next;
    logic [ID_W-1:0]     id_reg;
    logic [6:0]          dl_reg;
    logic [PROFIT_W-1:0] profit_reg;

    always_comb
    begin
        live_next = live_reg;
        if (clear)
            live_next = 1'b0;
        else if (load)
            live_next = 1'b1;
        else if (take)
            live_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live_reg <= 1'b0;
        else
            live_reg <= live_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            id_reg     <= load_id;
            dl_reg     <= load_deadline;
            profit_reg <= load_profit;
        end
    end

    assign live     = live_reg;
    assign id       = id_reg;
    assign deadline = dl_reg;
    assign profit   = profit_reg;

endmodule

>>> rtl/djs_slot_cell.sv
// One slot cell: occupancy, owner id and profit; shifts toward slot 1 on emit.
// Depends on djs_pkg.
module djs_slot_cell
    import djs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  slot_cmd_t           cmd,
    input  logic [6:0]          slot_index,
    input  logic                later_free,
    input  logic                in_used,
    input  logic [ID_W-1:0]     in_id,
    input  logic [PROFIT_W-1:0] in_profit,
    input  logic [ID_W-1:0]     place_id,
    input  logic [PROFIT_W-1:0] place_profit,
    output logic                free_here,
    output logic                used,
    output logic [ID_W-1:0]     id,
    output logic [PROFIT_W-1:0] profit
);

    logic                used_reg, used_next;
    logic [ID_W-1:0]     id_reg;
    logic [PROFIT_W-1:0] profit_reg;
    logic                hit;

    // Free and within the deadline: candidate slot.
    assign free_here = !used_reg && (slot_index <= cmd.deadline);
    // Latest candidate wins: no later cell is a candidate.
    assign hit = cmd.place && free_here && !later_free;

    always_comb
    begin
        used_next = used_reg;
        if (cmd.clear)
            used_next = 1'b0;
        else if (cmd.shift)
            used_next = in_used;
        else if (hit)
            used_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= 1'b0;
        else
            used_reg <= used_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            id_reg     <= in_id;
            profit_reg <= in_profit;
        end
        else if (hit)
        begin
            id_reg     <= place_id;
            profit_reg <= place_profit;
        end
    end

    assign used   = used_reg;
    assign id     = id_reg;
    assign profit = profit_reg;

endmodule

>>> rtl/deadline_job_scheduler.sv
// Deadline job scheduler top level: job cell row, slot cell row, control.
// Steps: each job is loaded into the next job cell. After the last job, each pick scans
// the stored jobs for the largest live profit and then places it; the picks and a closing
// scan that finds no job are followed by a shift of the slot row out through slot 1.
// busy is high from the last job to the end of the slot walk, and through the empty
// result if there is one; receiver cannot stall. Reset clears count and slots.
module deadline_job_scheduler
    import djs_pkg::*;
#(
    parameter int MAX_JOBS  = 32,
    parameter int MAX_SLOTS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ID_W-1:0]     job_id,
    input  logic [DL_W-1:0]     deadline,
    input  logic [PROFIT_W-1:0] profit,
    input  logic                last_job,
    output logic                strobe,
    output logic                has_job,
    output logic [SLOT_W-1:0]   slot_number,
    output logic [ID_W-1:0]     scheduled_id,
    output logic [TOTAL_W-1:0]  total_profit,
    output logic                overflow,
    output logic                last_result
);

    localparam int JCW = $clog2(MAX_JOBS + 1);
    localparam int JIW = $clog2(MAX_JOBS);
    localparam int SCW = $clog2(MAX_SLOTS + 1);

    state_t                state_reg, state_next;
    logic [JCW-1:0]        count_reg;
    logic                  drop_reg;
    logic                  phase_reg;   // 0: search max, 1: place
    logic [JIW-1:0]        scan_reg, best_reg;
    logic                  found_reg;
    logic [SCW-1:0]        emit_reg;
    logic [TOTAL_W:0]      run_reg;
    logic                  any_reg;

    logic                  accept, store;
    logic [6:0]            dl_clamp;
    logic [MAX_JOBS-1:0]   j_live;
    logic [ID_W-1:0]       j_id [MAX_JOBS];
    logic [6:0]            j_dl [MAX_JOBS];
    logic [PROFIT_W-1:0]   j_pr [MAX_JOBS];
    logic                  clear_set;
    slot_cmd_t             scmd;
    logic [MAX_SLOTS:0]    later;
    logic [MAX_SLOTS-1:0]  s_free, s_used;
    logic [ID_W-1:0]       s_id [MAX_SLOTS+1];
    logic [PROFIT_W-1:0]   s_pr [MAX_SLOTS+1];
    logic                  cur_better;
    logic [TOTAL_W:0]      run_add;
    logic                  emit_any;

    assign busy   = (state_reg != ST_LOAD);
    assign accept = start && !busy;
    assign store  = accept && (count_reg < JCW'(MAX_JOBS));
    assign dl_clamp = (deadline > DL_W'(MAX_SLOTS)) ? 7'(MAX_SLOTS) : 7'(deadline);

    genvar g;
    generate
        for (g = 0; g < MAX_JOBS; g++)
        begin : g_job
            djs_job_cell u_job (
                .clk          (clk),
                .rst_n        (rst_n),
                .clear        (clear_set),
                .load         (store && (count_reg[JIW-1:0] == JIW'(g))),
                .load_id      (job_id),
                .load_deadline(dl_clamp),
                .load_profit  (profit),
                .take         ((state_reg == ST_PLACE) && phase_reg && found_reg
                               && (best_reg == JIW'(g))),
                .live         (j_live[g]),
                .id           (j_id[g]),
                .deadline     (j_dl[g]),
                .profit       (j_pr[g])
            );
        end
    endgenerate

    assign later[MAX_SLOTS] = 1'b0;
    assign s_id[MAX_SLOTS]  = '0;
    assign s_pr[MAX_SLOTS]  = '0;

    always_comb
    begin
        scmd.clear    = clear_set;
        scmd.place    = (state_reg == ST_PLACE) && phase_reg && found_reg;
        scmd.deadline = j_dl[best_reg];
        scmd.shift    = (state_reg == ST_EMIT);
    end

    generate
        for (g = 0; g < MAX_SLOTS; g++)
        begin : g_slot
            logic nxt_used;
            assign nxt_used = (g == MAX_SLOTS - 1) ? 1'b0 : s_used[(g + 1) % MAX_SLOTS];
            assign later[g] = later[g + 1] || s_free[g];
            djs_slot_cell u_slot (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (scmd),
                .slot_index  (7'(g + 1)),
                .later_free  (later[g + 1]),
                .in_used     (nxt_used),
                .in_id       (s_id[g + 1]),
                .in_profit   (s_pr[g + 1]),
                .place_id    (j_id[best_reg]),
                .place_profit(j_pr[best_reg]),
                .free_here   (s_free[g]),
                .used        (s_used[g]),
                .id          (s_id[g]),
                .profit      (s_pr[g])
            );
        end
    endgenerate

    // Strictly greater keeps the earlier-loaded job on ties.
    assign cur_better = j_live[scan_reg] && (!found_reg || (j_pr[scan_reg] > j_pr[best_reg]));
    assign run_add    = run_reg + (TOTAL_W + 1)'(s_pr[0]);
    // A slot seen so far, including the one at the head of the row this cycle.
    assign emit_any   = any_reg || s_used[0];
    assign clear_set  = (state_reg == ST_EMIT && emit_reg == SCW'(MAX_SLOTS - 1) && emit_any)
                     || (state_reg == ST_EMPTY);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:  if (accept && last_job) state_next = ST_PLACE;
            ST_PLACE: if (phase_reg && !found_reg) state_next = ST_EMIT;
            ST_EMIT:
                if (emit_reg == SCW'(MAX_SLOTS - 1))
                    state_next = emit_any ? ST_LOAD : ST_EMPTY;
            ST_EMPTY: state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            phase_reg <= 1'b0;
            scan_reg  <= '0;
            best_reg  <= '0;
            found_reg <= 1'b0;
            emit_reg  <= '0;
            run_reg   <= '0;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (store)
                count_reg <= count_reg + 1'b1;
            else if (accept)
                drop_reg <= 1'b1;
            if (clear_set)
            begin
                count_reg <= '0;
                drop_reg  <= 1'b0;
            end
            unique case (state_reg)
                ST_PLACE:
                begin
                    if (!phase_reg)
                    begin
                        // Walk the job row for the largest live profit.
                        if (cur_better)
                        begin
                            best_reg  <= scan_reg;
                            found_reg <= 1'b1;
                        end
                        if (JCW'(scan_reg) == count_reg - 1'b1 || count_reg == '0)
                            phase_reg <= 1'b1;
                        else
                            scan_reg <= scan_reg + 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                        emit_reg  <= '0;
                        run_reg   <= '0;
                        any_reg   <= 1'b0;
                    end
                end
                ST_EMIT:
                begin
                    emit_reg <= emit_reg + 1'b1;
                    if (s_used[0])
                    begin
                        run_reg <= run_add;
                        any_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Final result: last used slot, i.e. no used slot above cell 0.
    logic more_used;
    assign more_used = |(s_used >> 1);

    always_comb
    begin
        strobe       = 1'b0;
        has_job      = 1'b0;
        slot_number  = '0;
        scheduled_id = '0;
        total_profit = '0;
        overflow     = drop_reg;
        last_result  = 1'b0;
        if (state_reg == ST_EMIT && s_used[0])
        begin
            strobe       = 1'b1;
            has_job      = 1'b1;
            slot_number  = SLOT_W'(emit_reg + 1'b1);
            scheduled_id = s_id[0];
            total_profit = run_add[TOTAL_W] ? TOTAL_MAX : run_add[TOTAL_W-1:0];
            last_result  = !more_used;
        end
        else if (state_reg == ST_EMPTY)
        begin
            strobe      = 1'b1;
            last_result = 1'b1;
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !accept) else $error("accept while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= JCW'(MAX_JOBS)) else $error("job count over limit");
    a_empty_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMPTY |=> state_reg == ST_LOAD) else $error("empty result repeated");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_result) |=> !strobe) else $error("result after final result");

endmodule

>>> test/tb.sv
// Testbench for deadline_job_scheduler: random and directed job sets, greedy predictor.
// Depends on djs_pkg and the deadline_job_scheduler RTL.
`timescale 1ns / 100ps

module tb;
    import djs_pkg::*;

    localparam int MAX_JOBS  = 32;
    localparam int MAX_SLOTS = 32;

    typedef struct packed {
        logic [ID_W-1:0]     job_id;
        logic [DL_W-1:0]     deadline;
        logic [PROFIT_W-1:0] profit;
        logic                last_job;
        logic                drain;   // hold off until every expected result has come
    } job_t;

    typedef struct packed {
        logic                has_job;
        logic [SLOT_W-1:0]   slot_number;
        logic [ID_W-1:0]     scheduled_id;
        logic [TOTAL_W-1:0]  total_profit;
        logic                overflow;
        logic                last_result;
    } slot_rec_t;

    logic clk, rst_n, start, busy, last_job, strobe;
    logic [ID_W-1:0] job_id;
    logic [DL_W-1:0] deadline;
    logic [PROFIT_W-1:0] profit;
    logic has_job, overflow, last_result;
    logic [SLOT_W-1:0] slot_number;
    logic [ID_W-1:0] scheduled_id;
    logic [TOTAL_W-1:0] total_profit;

    job_t      pending_jobs[$];
    slot_rec_t expected_slots[$];
    int        fail_count = 0;
    bit        stimulus_done = 0;

    // predictor state
    logic [ID_W-1:0]     set_ids[MAX_JOBS];
    logic [5:0]          set_dls[MAX_JOBS];
    logic [PROFIT_W-1:0] set_profits[MAX_JOBS];
    int                  set_count = 0;
    bit                  set_dropped = 0;

    deadline_job_scheduler #(.MAX_JOBS(MAX_JOBS), .MAX_SLOTS(MAX_SLOTS)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .job_id(job_id), .deadline(deadline), .profit(profit), .last_job(last_job),
        .strobe(strobe), .has_job(has_job), .slot_number(slot_number),
        .scheduled_id(scheduled_id), .total_profit(total_profit),
        .overflow(overflow), .last_result(last_result)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    task automatic schedule_set();
        bit taken[MAX_JOBS];
        bit used[MAX_SLOTS+1];
        int owner[MAX_SLOTS+1];
        int best, n;
        bit found;
        logic [22:0] run;
        slot_rec_t rec;
        for (int k = 0; k < MAX_JOBS; k++) taken[k] = 0;
        for (int s = 0; s <= MAX_SLOTS; s++) used[s] = 0;
        for (int r = 0; r < set_count; r++)
        begin
            found = 0;
            best = 0;
            for (int k = 0; k < set_count; k++)
                if (!taken[k] && (!found || set_profits[k] > set_profits[best]))
                begin
                    best = k;
                    found = 1;
                end
            taken[best] = 1;
            for (int s = set_dls[best]; s > 0; s--)
                if (!used[s])
                begin
                    used[s] = 1;
                    owner[s] = best;
                    break;
                end
        end
        run = 0;
        n = 0;
        for (int s = 1; s <= MAX_SLOTS; s++)
            if (used[s])
            begin
                run += set_profits[owner[s]];
                rec.has_job = 1;
                rec.slot_number = s[SLOT_W-1:0];
                rec.scheduled_id = set_ids[owner[s]];
                rec.total_profit = (run > TOTAL_MAX) ? TOTAL_MAX : run[TOTAL_W-1:0];
                rec.overflow = set_dropped;
                rec.last_result = 0;
                expected_slots.push_back(rec);
                n++;
            end
        if (n == 0)
        begin
            rec = '0;
            rec.overflow = set_dropped;
            rec.last_result = 1;
            expected_slots.push_back(rec);
        end
        else
            expected_slots[$].last_result = 1;
        set_count = 0;
        set_dropped = 0;
    endtask

    task automatic accept_job(job_t j);
        if (set_count < MAX_JOBS)
        begin
            set_ids[set_count] = j.job_id;
            set_dls[set_count] = (j.deadline > MAX_SLOTS) ? 6'(MAX_SLOTS) : j.deadline[5:0];
            set_profits[set_count] = j.profit;
            set_count++;
        end
        else
            set_dropped = 1;
        if (j.last_job)
            schedule_set();
    endtask

    function automatic job_t make_job(int id, int dl, int pr, bit last);
        job_t j;
        j.job_id = ID_W'(id);
        j.deadline = DL_W'(dl);
        j.profit = PROFIT_W'(pr);
        j.last_job = last;
        j.drain = 0;
        return j;
    endfunction

    // driver: one transfer per accepted start, random gap before each item
    int  gap_left = 0;
    bit  holding = 0;
    job_t cur;
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 0;
        else if (start && !busy)
            ;   // handled at posedge; next item chosen below
        if (rst_n)
        begin
            if (start)
                ; // still waiting for acceptance
            else if (!holding && pending_jobs.size() > 0)
            begin
                cur = pending_jobs.pop_front();
                holding = 1;
                gap_left = $urandom_range(0, 18);
                if ($urandom_range(0, 3) == 0) gap_left = 0;
            end
            if (!start && holding)
            begin
                if (cur.drain && expected_slots.size() > 0)
                    ;
                else if (gap_left > 0)
                    gap_left--;
                else
                begin
                    start <= 1;
                    job_id <= cur.job_id;
                    deadline <= cur.deadline;
                    profit <= cur.profit;
                    last_job <= cur.last_job;
                    holding = 0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            accept_job(make_job(job_id, deadline, profit, last_job));
            start <= 0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        slot_rec_t exp_r;
        if (rst_n && strobe)
        begin
            if (expected_slots.size() == 0)
            begin
                $error("unexpected result slot %0d id %0d", slot_number, scheduled_id);
                fail_count++;
            end
            else
            begin
                exp_r = expected_slots.pop_front();
                if (has_job !== exp_r.has_job)
                begin
                    $error("has_job exp %0d got %0d", exp_r.has_job, has_job);
                    fail_count++;
                end
                if (slot_number !== exp_r.slot_number)
                begin
                    $error("slot_number exp %0d got %0d", exp_r.slot_number, slot_number);
                    fail_count++;
                end
                if (scheduled_id !== exp_r.scheduled_id)
                begin
                    $error("scheduled_id exp %0d got %0d", exp_r.scheduled_id, scheduled_id);
                    fail_count++;
                end
                if (total_profit !== exp_r.total_profit)
                begin
                    $error("total_profit exp %0d got %0d", exp_r.total_profit, total_profit);
                    fail_count++;
                end
                if (overflow !== exp_r.overflow)
                begin
                    $error("overflow exp %0d got %0d", exp_r.overflow, overflow);
                    fail_count++;
                end
                if (last_result !== exp_r.last_result)
                begin
                    $error("last_result exp %0d got %0d", exp_r.last_result, last_result);
                    fail_count++;
                end
            end
        end
    end

    task automatic add_random_set(int n, int dl_max, int pr_max);
        job_t j;
        for (int i = 0; i < n; i++)
        begin
            j = make_job($urandom_range(0, 255), $urandom_range(0, dl_max),
                         $urandom_range(0, pr_max), i == n - 1);
            pending_jobs.push_back(j);
        end
    endtask

    initial
    begin
        job_t j;
        int n;
        rst_n = 0;
        start = 0;
        job_id = 0;
        deadline = 0;
        profit = 0;
        last_job = 0;
        // directed: single job, zero deadline, extremes, clamp, ties
        pending_jobs.push_back(make_job(0, 0, 0, 1));                // nothing scheduled
        pending_jobs.push_back(make_job(255, 255, 65535, 1));        // clamped deadline
        pending_jobs.push_back(make_job(8'hAA, 1, 16'h5555, 0));
        pending_jobs.push_back(make_job(8'h55, 1, 16'h5555, 0));     // tie goes to first
        pending_jobs.push_back(make_job(8'h0F, 2, 16'hAAAA, 0));
        pending_jobs.push_back(make_job(8'hF0, 33, 16'h00FF, 0));
        pending_jobs.push_back(make_job(8'h11, 32, 16'hFF00, 1));
        pending_jobs.push_back(make_job(1, 0, 500, 0));
        pending_jobs.push_back(make_job(2, 3, 1, 1));
        j = make_job(3, 0, 0, 1);
        j.drain = 1;
        pending_jobs.push_back(j);
        // overflow: 34 jobs, the last two ignored, the last one still closes the set
        for (int i = 0; i < 34; i++)
            pending_jobs.push_back(make_job(i, 40, 65535 - i, i == 33));
        // random sets: mostly small, a few full or overfull
        n = 0;
        while (n < 420)
        begin
            case ($urandom_range(0, 9))
                0: begin add_random_set(33 + $urandom_range(0, 3), 255, 65535); n += 34; end
                1: begin add_random_set($urandom_range(1, 32), 40, 65535); n += 16; end
                default: begin add_random_set($urandom_range(1, 8), 10, 65535); n += 4; end
            endcase
            if ($urandom_range(0, 15) == 0)
                pending_jobs[$].drain = 1;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        wait (pending_jobs.size() == 0 && !holding);
        @(posedge clk);
        wait (!start);
        wait (expected_slots.size() == 0);
        repeat (150) @(posedge clk);
        if (fail_count == 0 && expected_slots.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

>>> files.f
rtl/djs_pkg.sv
rtl/djs_job_cell.sv
rtl/djs_slot_cell.sv
rtl/deadline_job_scheduler.sv
test/tb.sv
